// ===== design/rcfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared widths, register indexes and item types for the frame parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int CHIDX_W = 4;
  localparam int COUNT_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEGATE_MASK = 2'd1;

  localparam logic [WORD_W-1:0] WORD_MIN = 16'h8000;
  localparam logic [WORD_W-1:0] WORD_MAX = 16'h7FFF;

  // Outcome of one complement-checked word pair.
  typedef struct packed {
    logic              verified;
    logic              mismatch;
    logic [WORD_W-1:0] word;
  } word_ev_t;

  // One emitted channel item.
  typedef struct packed {
    logic [CHIDX_W-1:0]       channel_index;
    logic signed [WORD_W-1:0] channel_value;
    logic                     frame_complete;
    logic [COUNT_W-1:0]       frame_count;
    logic [COUNT_W-1:0]       error_count;
  } result_t;

endpackage

// ===== design/rcfp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfp channel interfaces
// Byte input stream, channel result stream and register write channel.
// ----------------------------------------------------------------------------
interface rcfp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [rcfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcfp_chan_if;
  logic                               valid;
  logic                               ready;
  logic [rcfp_pkg::CHIDX_W-1:0]       channel_index;
  logic signed [rcfp_pkg::WORD_W-1:0] channel_value;
  logic                               frame_complete;
  logic [rcfp_pkg::COUNT_W-1:0]       frame_count;
  logic [rcfp_pkg::COUNT_W-1:0]       error_count;

  modport source (output valid, output channel_index, output channel_value,
                  output frame_complete, output frame_count, output error_count,
                  input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input frame_complete, input frame_count, input error_count,
                  output ready);
endinterface

interface rcfp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rcfp_pkg::CFG_IDX_W-1:0] index;
  logic [rcfp_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/rcfp_word_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfp_word_check
// Pairs bytes into words, then checks each word against its complement.
// ----------------------------------------------------------------------------
module rcfp_word_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [rcfp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [rcfp_pkg::WORD_W-1:0]   sync_word,
  input  logic                          in_frame,
  output rcfp_pkg::word_ev_t            ev
);
  import rcfp_pkg::*;

  logic              expect_low_byte, expect_low_byte_next;
  logic              expect_complement, expect_complement_next;
  logic [BYTE_W-1:0] high_byte_hold;
  logic [WORD_W-1:0] normal_word_hold;
  logic [WORD_W-1:0] word;

  assign word = {high_byte_hold, rx_byte};

  always_comb begin
    expect_low_byte_next   = expect_low_byte;
    expect_complement_next = expect_complement;
    ev          = '0;
    ev.word     = normal_word_hold;
    if (!expect_low_byte) begin
      // hunting: only a sync high byte opens a word
      expect_low_byte_next = in_frame || expect_complement ||
                             (rx_byte == sync_word[WORD_W-1:BYTE_W]);
    end else begin
      expect_low_byte_next = 1'b0;
      if (!expect_complement) begin
        expect_complement_next = 1'b1;
      end else begin
        expect_complement_next = 1'b0;
        if (normal_word_hold == ~word) begin
          ev.verified = fire;
        end else begin
          ev.mismatch = fire;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_low_byte   <= 1'b0;
      expect_complement <= 1'b0;
    end else if (fire) begin
      expect_low_byte   <= expect_low_byte_next;
      expect_complement <= expect_complement_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (!expect_low_byte) begin
        high_byte_hold <= rx_byte;
      end else if (!expect_complement) begin
        normal_word_hold <= word;
      end
    end
  end

endmodule

// ===== design/rcfp_frame_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfp_frame_track
// Frame sync, channel sequencing, sign handling and frame/error counters.
// ----------------------------------------------------------------------------
module rcfp_frame_track #(
  parameter int CHANNELS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rcfp_pkg::word_ev_t          ev,
  input  logic [rcfp_pkg::WORD_W-1:0] sync_word,
  input  logic [rcfp_pkg::WORD_W-1:0] negate_mask,
  output logic                        in_frame,
  output logic                        res_valid,
  output rcfp_pkg::result_t           res
);
  import rcfp_pkg::*;

  localparam logic [CHIDX_W-1:0] LAST_CH = CHIDX_W'(CHANNELS - 1);

  logic               in_frame_next;
  logic [CHIDX_W-1:0] next_channel, next_channel_next;
  logic [COUNT_W-1:0] frames_seen, frames_seen_next;
  logic [COUNT_W-1:0] errors_seen, errors_seen_next;
  logic               last;
  logic [WORD_W-1:0]  signed_word;

  assign last = (next_channel >= LAST_CH);

  // negation, with the minimum saturating to the maximum
  always_comb begin
    if (negate_mask[next_channel]) begin
      signed_word = (ev.word == WORD_MIN) ? WORD_MAX : (~ev.word + 1'b1);
    end else begin
      signed_word = ev.word;
    end
  end

  always_comb begin
    in_frame_next     = in_frame;
    next_channel_next = next_channel;
    frames_seen_next  = frames_seen;
    errors_seen_next  = errors_seen;
    res_valid         = 1'b0;
    if (ev.mismatch) begin
      in_frame_next     = 1'b0;
      next_channel_next = '0;
      errors_seen_next  = errors_seen + 1'b1;
    end else if (ev.verified) begin
      if (ev.word == sync_word) begin
        in_frame_next     = 1'b1;
        next_channel_next = '0;
      end else if (in_frame) begin
        res_valid = 1'b1;
        if (last) begin
          in_frame_next     = 1'b0;
          next_channel_next = '0;
          frames_seen_next  = frames_seen + 1'b1;
        end else begin
          next_channel_next = next_channel + 1'b1;
        end
      end
    end
    res.channel_index  = next_channel;
    res.channel_value  = signed_word;
    res.frame_complete = last;
    res.frame_count    = frames_seen_next;
    res.error_count    = errors_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      next_channel <= '0;
      frames_seen  <= '0;
      errors_seen  <= '0;
    end else begin
      in_frame     <= in_frame_next;
      next_channel <= next_channel_next;
      frames_seen  <= frames_seen_next;
      errors_seen  <= errors_seen_next;
    end
  end

endmodule

// ===== design/rc_complement_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_complement_frame_parser_core
// Complement-checked radio frame parser: bytes in, channel items out.
// ----------------------------------------------------------------------------
// Usage:
//  - rx: one received byte per item. Bytes pair into high-then-low words;
//    each word is followed by its bitwise complement. A verified word equal
//    to sync_word starts a frame; the next CHANNELS verified words come out
//    on chan with their index, negated per negate_mask (min saturates).
//  - chan: one item per verified channel word; frame_complete marks the last
//    channel, frame_count/error_count are the running wrapping totals.
//  - cfg: index 0 writes sync_word, 1 writes negate_mask. Always ready;
//    write only while idle. Other indexes are ignored.
//  - Output: a result enters the output buffer as its last byte is taken.
//  - Throughput: one byte per cycle while rx is ready; single-pass decode.
//  - Stall: results sit in a two-entry output buffer (output register plus
//    skid). rx stays ready until both entries are full.
//  - Reset (rst, synchronous): parser hunts for sync, counters and registers
//    clear, output buffer empties.
// ----------------------------------------------------------------------------
module rc_complement_frame_parser_core #(
  parameter int CHANNELS = 8
) (
  input logic         clk,
  input logic         rst,
  rcfp_byte_if.sink   rx,
  rcfp_chan_if.source chan,
  rcfp_cfg_if.sink    cfg
);
  import rcfp_pkg::*;

  logic [WORD_W-1:0] sync_word;
  logic [WORD_W-1:0] negate_mask;
  logic              fire;
  logic              in_frame;
  word_ev_t          ev;
  logic              res_valid;
  result_t           res;

  // output buffer
  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    push, pop;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word   <= '0;
      negate_mask <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SYNC_WORD:   sync_word   <= cfg.data;
        REG_NEGATE_MASK: negate_mask <= cfg.data;
        default: ;
      endcase
    end
  end

  // byte accept: keep going while there is room for one more result
  assign rx.ready = !skid_valid;
  assign fire     = rx.valid && rx.ready;

  rcfp_word_check u_word (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (rx.rx_byte),
    .sync_word (sync_word),
    .in_frame  (in_frame),
    .ev        (ev)
  );

  rcfp_frame_track #(
    .CHANNELS (CHANNELS)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .ev          (ev),
    .sync_word   (sync_word),
    .negate_mask (negate_mask),
    .in_frame    (in_frame),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign push = res_valid;
  assign pop  = out_valid && chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid) begin
      out_data <= res;
    end else if (pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end else if (push) begin
      skid_data <= res;
    end
  end

  assign chan.valid          = out_valid;
  assign chan.channel_index  = out_data.channel_index;
  assign chan.channel_value  = out_data.channel_value;
  assign chan.frame_complete = out_data.frame_complete;
  assign chan.frame_count    = out_data.frame_count;
  assign chan.error_count    = out_data.error_count;

  // ordering: the skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  // channel indexes stay inside the configured frame length
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    chan.valid |-> (chan.channel_index <= CHIDX_W'(CHANNELS - 1)))
    else $error("channel index beyond frame length");

  // frame end is flagged on the last channel only
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (chan.valid && chan.frame_complete) |->
      (chan.channel_index == CHIDX_W'(CHANNELS - 1)))
    else $error("frame_complete on a non-final channel");

  // a result cannot appear without a byte taken the cycle before
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && !$past(rst)) |-> $past(fire))
    else $error("result without an accepted byte");

endmodule

// ===== tb/rcfp_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfp_frame_checker
// Watches the byte, channel and register channels of the frame parser. It
// tracks the parser state from accepted bytes, queues the channel items
// those bytes should produce, and compares every emitted item with them.
// ----------------------------------------------------------------------------
module rcfp_frame_checker #(
  parameter int CHANNELS = 8
) (
  input  logic  clk,
  input  logic  rst,
  rcfp_byte_if  rx,
  rcfp_chan_if  chan,
  rcfp_cfg_if   cfg,
  output int    mismatches,
  output int    items_due
);
  import rcfp_pkg::*;

  // register copies
  logic [WORD_W-1:0]  sync_word;
  logic [WORD_W-1:0]  negate_mask;

  // parser state
  logic               want_low;
  logic               want_compl;
  logic               framing;
  logic [CHIDX_W-1:0] next_ch;
  logic [BYTE_W-1:0]  high_hold;
  logic [WORD_W-1:0]  normal_hold;
  logic [COUNT_W-1:0] frames;
  logic [COUNT_W-1:0] errors;

  result_t            due_channels[$];
  result_t            head;

  task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0]  word;
    logic [CHIDX_W-1:0] ch;
    logic               last;
    result_t            item;
    if (!want_low) begin
      high_hold = b;
      // while hunting, only a sync high byte opens a word
      if (framing || want_compl || b == sync_word[WORD_W-1:BYTE_W]) want_low = 1'b1;
    end else begin
      want_low = 1'b0;
      word = {high_hold, b};
      if (!want_compl) begin
        normal_hold = word;
        want_compl = 1'b1;
      end else begin
        want_compl = 1'b0;
        if (normal_hold != ~word) begin
          framing = 1'b0;
          next_ch = '0;
          errors = errors + 1'b1;
        end else if (normal_hold == sync_word) begin
          framing = 1'b1;
          next_ch = '0;
        end else if (framing) begin
          ch = next_ch;
          last = (int'(ch) + 1 >= CHANNELS);
          if (last) begin
            framing = 1'b0;
            next_ch = '0;
            frames = frames + 1'b1;
          end else begin
            next_ch = ch + 1'b1;
          end
          item.channel_index = ch;
          if (!negate_mask[ch]) begin
            item.channel_value = normal_hold;
          end else if (normal_hold == WORD_MIN) begin
            item.channel_value = WORD_MAX;
          end else begin
            item.channel_value = WORD_W'(-normal_hold);
          end
          item.frame_complete = last;
          item.frame_count = frames;
          item.error_count = errors;
          due_channels.push_back(item);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sync_word = '0;
      negate_mask = '0;
      want_low = 1'b0;
      want_compl = 1'b0;
      framing = 1'b0;
      next_ch = '0;
      high_hold = '0;
      normal_hold = '0;
      frames = '0;
      errors = '0;
      due_channels.delete();
      items_due <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SYNC_WORD:   sync_word = cfg.data;
          REG_NEGATE_MASK: negate_mask = cfg.data;
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) decode_rx_byte(rx.rx_byte);
      if (chan.valid && chan.ready) begin
        if (due_channels.size() == 0) begin
          $display("%0t: channel item expected none, got index %0d value %0d", $time,
                   chan.channel_index, chan.channel_value);
          mismatches = mismatches + 1;
        end else begin
          head = due_channels.pop_front();
          check_field("channel_index", head.channel_index, chan.channel_index);
          check_field("channel_value", head.channel_value, chan.channel_value);
          check_field("frame_complete", head.frame_complete, chan.frame_complete);
          check_field("frame_count", head.frame_count, chan.frame_count);
          check_field("error_count", head.error_count, chan.error_count);
        end
      end
      items_due <= due_channels.size();
    end
  end

endmodule

// ===== tb/tb_rc_complement_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_complement_frame_parser_core
// Drives byte streams into the frame parser under random idling on both
// sides and lets rcfp_frame_checker judge every channel item. A directed
// opening covers the hunting, sync and mismatch corners; then framed
// random traffic runs under several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_rc_complement_frame_parser_core;
  import rcfp_pkg::*;

  localparam int CHANNELS    = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 120;     // minimum random bytes per register setting

  logic clk;
  logic rst;
  logic calm;        // no idling on either side while set
  int   cycles;
  int   mismatches;
  int   items_due;

  logic [BYTE_W-1:0] byte_plan[$];

  rcfp_byte_if rx_bus();
  rcfp_chan_if chan_bus();
  rcfp_cfg_if  cfg_bus();

  rc_complement_frame_parser_core #(
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_bus),
    .chan (chan_bus),
    .cfg  (cfg_bus)
  );

  rcfp_frame_checker #(
    .CHANNELS(CHANNELS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_bus),
    .chan       (chan_bus),
    .cfg        (cfg_bus),
    .mismatches (mismatches),
    .items_due  (items_due)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run guard: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side stalls in about 23 percent of cycles, never during a calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      chan_bus.ready <= 1'b0;
    end else begin
      chan_bus.ready <= calm || ($urandom_range(0, 99) >= 23);
    end
  end

  // One byte item: optional idle cycles, then hold valid until taken.
  // valid is left high so back-to-back items need no second write per step.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!calm) begin
      while ($urandom_range(0, 99) < 23) begin
        rx_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    rx_bus.valid <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk); while (!rx_bus.ready);
  endtask

  task automatic flush_plan();
    while (byte_plan.size() != 0) send_byte(byte_plan.pop_front());
  endtask

  // Stop sending and wait out every expected channel item.
  task automatic drain();
    rx_bus.valid <= 1'b0;
    do @(posedge clk); while (items_due != 0);
    repeat (3) @(posedge clk);
  endtask

  // Registers are only written with the parser idle.
  task automatic reconfigure(input logic [WORD_W-1:0] sync_val,
                             input logic [WORD_W-1:0] mask_val);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_SYNC_WORD;
    cfg_bus.data <= sync_val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.index <= REG_NEGATE_MASK;
    cfg_bus.data <= mask_val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Word plus its complement, high byte first. A bad pair gets one
  // complement bit flipped.
  task automatic plan_word(input logic [WORD_W-1:0] w, input logic bad);
    logic [WORD_W-1:0] cw;
    cw = ~w;
    if (bad) cw = cw ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1));
    byte_plan.push_back(w[15:8]);
    byte_plan.push_back(w[7:0]);
    byte_plan.push_back(cw[15:8]);
    byte_plan.push_back(cw[7:0]);
  endtask

  // Channel data leans on the signed extremes and on all-zeros / all-ones.
  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Sync followed by up to a full set of channels. Now and then a sync
  // restarts the frame or a broken complement aborts it.
  task automatic plan_frame(input logic [WORD_W-1:0] sync_val, input int words);
    int r;
    plan_word(sync_val, 1'b0);
    for (int i = 0; i < words; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        plan_word(pick_value(), 1'b1);
        break;
      end else if (r < 8) begin
        plan_word(sync_val, 1'b0);
      end else begin
        plan_word(pick_value(), 1'b0);
      end
    end
  endtask

  // Mostly complete frames with random content; the rest are cut-short
  // frames and loose noise bytes that can knock the byte pairing out of step.
  task automatic run_random_phase(input logic [WORD_W-1:0] sync_val);
    int sent;
    int r;
    sent = 0;
    while (sent < PHASE_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        plan_frame(sync_val, CHANNELS);
      end else if (r < 85) begin
        plan_frame(sync_val, $urandom_range(0, CHANNELS - 1));
      end else begin
        repeat ($urandom_range(1, 5)) byte_plan.push_back(BYTE_W'($urandom));
      end
      sent += byte_plan.size();
      flush_plan();
    end
  endtask

  initial begin
    logic [WORD_W-1:0] sync_val;
    rst = 1'b1;
    calm = 1'b0;
    rx_bus.valid = 1'b0;
    rx_bus.rx_byte = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_SYNC_WORD;
    cfg_bus.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: sync 5AA5, only channel 0 negated.
    reconfigure(16'h5AA5, 16'h0001);
    byte_plan.push_back(8'h00);        // hunting: wrong high byte is dropped
    plan_word(16'h5AFF, 1'b0);         // verified but not sync, dropped
    plan_word(16'h5AA5, 1'b0);         // sync opens the frame
    plan_word(WORD_MIN, 1'b0);         // negated minimum saturates to max
    plan_word(16'h5AA5, 1'b0);         // sync mid-frame restarts at channel 0
    plan_word(16'h0001, 1'b0);         // channel 0 again, negated to -1
    plan_word(16'h1234, 1'b1);         // complement mismatch counts an error
    flush_plan();

    // Zero sync word with every channel negated.
    reconfigure(16'h0000, 16'hFFFF);
    run_random_phase(16'h0000);

    // All-ones sync word, no negation, and no idling on either side.
    calm = 1'b1;
    reconfigure(16'hFFFF, 16'h0000);
    run_random_phase(16'hFFFF);
    calm = 1'b0;

    // Random settings.
    repeat (2) begin
      sync_val = WORD_W'($urandom);
      reconfigure(sync_val, WORD_W'($urandom));
      run_random_phase(sync_val);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
